// ===== hw/rtl/tefu_pkg.sv =====
// ----------------------------------------------------------------------------
// tefu_pkg
// Shared types and codes for the task event-flag unit.
// ----------------------------------------------------------------------------
package tefu_pkg;

    typedef enum logic [2:0] {
        OP_WAIT    = 3'd0,
        OP_SEND    = 3'd1,
        OP_PULSE   = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_TIMEOUT = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_WOULD_BLOCK = 3'd1,
        ST_NOW_WAITING = 3'd2,
        ST_TIMED_OUT   = 3'd3,
        ST_BAD_TASK    = 3'd4
    } t_status;

    // register word index on the config port
    localparam logic [1:0] REG_TASK_COUNT = 2'd0;

    localparam int unsigned FIELD_SIG_BITS = 16;
    localparam int unsigned FIELD_TASK_BITS = 4;
    localparam logic [4:0] TASK_COUNT_RST = 5'd16;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // input transfer taken, latch item and start entry read
        logic exec;     // entry data ready and output free: update and load result
    } t_cmd;

endpackage

// ===== hw/rtl/tefu_ram.sv =====
// ----------------------------------------------------------------------------
// tefu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tefu_ram #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tefu_ctrl.sv =====
// ----------------------------------------------------------------------------
// tefu_ctrl
// Sequencing controller: input acceptance, entry read, execute, output valid.
// ----------------------------------------------------------------------------
module tefu_ctrl
    import tefu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   out_free;

    // output register can take a new result this cycle
    assign out_free = !r_out_vld || !i_stall;

    always_comb begin
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        n_state       = r_state;
        n_out_vld     = r_out_vld && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;

endmodule

// ===== hw/rtl/tefu_dpath.sv =====
// ----------------------------------------------------------------------------
// tefu_dpath
// Datapath: task entry store, waiting bits, flag update logic, result register.
// ----------------------------------------------------------------------------
module tefu_dpath
    import tefu_pkg::*;
#(
    parameter int unsigned NUM_TASKS   = 16,
    parameter int unsigned SIGNAL_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic [4:0]                 i_task_count,
    input  logic [2:0]                 i_op,
    input  logic [FIELD_TASK_BITS-1:0] i_task_req,
    input  logic [FIELD_SIG_BITS-1:0]  i_sig_mask,
    input  logic                       i_wait_all,
    input  logic                       i_may_block,
    output logic [2:0]                 o_status,
    output logic [FIELD_SIG_BITS-1:0]  o_sigs_out,
    output logic                       o_woke,
    output logic [FIELD_TASK_BITS-1:0] o_task_out
);

    localparam int unsigned SW = (SIGNAL_BITS < FIELD_SIG_BITS) ? SIGNAL_BITS
                                                                 : FIELD_SIG_BITS;
    localparam int unsigned TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int unsigned EW = 2 * SW + 1;

    // entry layout: {and_mode, wait_mask, pending}
    logic [FIELD_TASK_BITS+TW-1:0] req_ext;
    logic [TW-1:0]                 req_addr;

    logic [2:0]                 r_op;
    logic [FIELD_TASK_BITS-1:0] r_task;
    logic [TW-1:0]              r_addr;
    logic [SW-1:0]              r_sig;
    logic                       r_all;
    logic                       r_may_block;
    logic                       r_hit;

    logic [NUM_TASKS-1:0] r_entry_vld;
    logic [NUM_TASKS-1:0] r_waiting;

    logic [EW-1:0] rd_data;
    logic [EW-1:0] wr_data;
    logic          wr_en;

    logic [SW-1:0] pend;
    logic [SW-1:0] wmask;
    logic          amode;
    logic          wt;
    logic          bad;

    logic [SW-1:0] n_pend;
    logic [SW-1:0] n_wmask;
    logic          n_amode;
    logic          n_wt;
    logic          upd;
    logic [SW-1:0] got;
    logic [SW-1:0] wake;
    t_status       res_status;
    logic [SW-1:0] res_sigs;
    logic          res_woke;

    logic [2:0]                 r_status;
    logic [FIELD_SIG_BITS-1:0]  r_sigs;
    logic                       r_woke;
    logic [FIELD_TASK_BITS-1:0] r_task_out;

    assign req_ext  = {{TW{1'b0}}, i_task_req};
    assign req_addr = req_ext[TW-1:0];

    tefu_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_TASKS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.capture),
        .i_raddr (req_addr),
        .o_rdata (rd_data)
    );

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_op;
            r_task      <= i_task_req;
            r_addr      <= req_addr;
            r_sig       <= i_sig_mask[SW-1:0];
            r_all       <= i_wait_all;
            r_may_block <= i_may_block;
            r_hit       <= r_entry_vld[req_addr];
        end
    end

    // never-written entries read as zero
    assign pend  = r_hit ? rd_data[SW-1:0] : '0;
    assign wmask = r_hit ? rd_data[2*SW-1:SW] : '0;
    assign amode = r_hit ? rd_data[EW-1] : 1'b0;
    assign wt    = r_waiting[r_addr];
    // undefined ops are never rejected, whatever the task index
    assign bad   = (r_op <= OP_TIMEOUT)
                   && (({1'b0, r_task} >= i_task_count) || (32'(r_task) >= NUM_TASKS));

    always_comb begin
        n_pend     = pend;
        n_wmask    = wmask;
        n_amode    = amode;
        n_wt       = wt;
        upd        = 1'b0;
        got        = r_sig & pend;
        wake       = (pend | r_sig) & wmask;
        res_status = ST_OK;
        res_sigs   = '0;
        res_woke   = 1'b0;
        if (bad) begin
            res_status = ST_BAD_TASK;
        end else begin
            unique case (r_op)
                OP_WAIT: begin
                    upd     = 1'b1;
                    n_wt    = 1'b0;
                    n_amode = r_all;
                    n_wmask = r_sig;
                    if (r_all && (got != r_sig)) begin
                        got = '0;
                    end
                    if (got != '0) begin
                        n_pend   = pend & ~got;
                        res_sigs = got;
                    end else if (!r_may_block) begin
                        res_status = ST_WOULD_BLOCK;
                    end else begin
                        n_wt       = 1'b1;
                        res_status = ST_NOW_WAITING;
                    end
                end
                OP_SEND, OP_PULSE: begin
                    upd    = 1'b1;
                    n_pend = (r_op == OP_PULSE) ? (pend & ~r_sig) : (pend | r_sig);
                    if (wt) begin
                        if (amode && (wake != wmask)) begin
                            wake = '0;
                        end
                        if (wake != '0) begin
                            n_pend   = n_pend & ~wake;
                            n_wt     = 1'b0;
                            res_sigs = wake;
                            res_woke = 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    upd    = 1'b1;
                    n_pend = pend & ~r_sig;
                end
                OP_TIMEOUT: begin
                    if (wt) begin
                        upd        = 1'b1;
                        n_wt       = 1'b0;
                        res_status = ST_TIMED_OUT;
                        res_woke   = 1'b1;
                    end
                end
                default: begin
                    // undefined op: no effect
                end
            endcase
        end
    end

    assign wr_en   = i_cmd.exec && upd;
    assign wr_data = {n_amode, n_wmask, n_pend};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
            r_waiting   <= '0;
        end else if (wr_en) begin
            r_entry_vld[r_addr] <= 1'b1;
            r_waiting[r_addr]   <= n_wt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status   <= res_status;
            r_sigs     <= FIELD_SIG_BITS'(res_sigs);
            r_woke     <= res_woke;
            r_task_out <= r_task;
        end
    end

    assign o_status   = r_status;
    assign o_sigs_out = r_sigs;
    assign o_woke     = r_woke;
    assign o_task_out = r_task_out;

endmodule

// ===== hw/rtl/task_event_flags_unit.sv =====
// ----------------------------------------------------------------------------
// task_event_flags_unit
// Per-task event flags: wait, send, pulse, clear and timeout operations.
// ----------------------------------------------------------------------------
// the item is latched and its task entry read on the input transfer; the
//   result register loads from S_EXEC once the output register is free
// a new item is taken only after the current one has executed, since the
//   registered read of the task entry RAM is followed by its read-modify-write
// reset: synchronous, active low; task_count returns to 16, all entries read
//   as zero and no task is waiting, with no clearing pass
module task_event_flags_unit
    import tefu_pkg::*;
#(
    parameter int unsigned NUM_TASKS   = 16,
    parameter int unsigned SIGNAL_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // item input
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [2:0]                 i_op,
    input  logic [FIELD_TASK_BITS-1:0] i_task_req,
    input  logic [FIELD_SIG_BITS-1:0]  i_sig_mask,
    input  logic                       i_wait_all,
    input  logic                       i_may_block,
    // result output
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [2:0]                 o_status,
    output logic [FIELD_SIG_BITS-1:0]  o_sigs_out,
    output logic                       o_woke,
    output logic [FIELD_TASK_BITS-1:0] o_task_out,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    t_cmd       cmd;
    logic [4:0] r_task_count;
    logic       reg_sel;

    assign reg_sel = ((paddr >> 2) == REG_TASK_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? 32'(r_task_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= TASK_COUNT_RST;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_task_count <= pwdata[4:0];
        end
    end

    tefu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    tefu_dpath #(
        .NUM_TASKS   (NUM_TASKS),
        .SIGNAL_BITS (SIGNAL_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_task_count (r_task_count),
        .i_op         (i_op),
        .i_task_req   (i_task_req),
        .i_sig_mask   (i_sig_mask),
        .i_wait_all   (i_wait_all),
        .i_may_block  (i_may_block),
        .o_status     (o_status),
        .o_sigs_out   (o_sigs_out),
        .o_woke       (o_woke),
        .o_task_out   (o_task_out)
    );

endmodule

// ===== verif/task_event_flags_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_event_flags_checker
// Follows the item, result and register transfers of the event-flag unit,
// keeps its own copy of the per-task flag state and compares every result
// field with the predicted one, oldest first.
// ----------------------------------------------------------------------------
module task_event_flags_checker
    import tefu_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       o_stall,
    input  logic [2:0]                 i_op,
    input  logic [FIELD_TASK_BITS-1:0] i_task_req,
    input  logic [FIELD_SIG_BITS-1:0]  i_sig_mask,
    input  logic                       i_wait_all,
    input  logic                       i_may_block,
    input  logic                       o_valid,
    input  logic                       i_stall,
    input  logic [2:0]                 o_status,
    input  logic [FIELD_SIG_BITS-1:0]  o_sigs_out,
    input  logic                       o_woke,
    input  logic [FIELD_TASK_BITS-1:0] o_task_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output int                         o_fail_count,
    output int                         o_results_due
);

    localparam int          SLOTS           = 16;
    localparam logic [1:0]  TASK_COUNT_ADDR = REG_TASK_COUNT << 2;

    typedef struct packed {
        t_status                    status;
        logic [FIELD_SIG_BITS-1:0]  sigs;
        logic                       woke;
        logic [FIELD_TASK_BITS-1:0] task_id;
    } t_event_result;

    logic [FIELD_SIG_BITS-1:0] pend_sigs [SLOTS];
    logic [FIELD_SIG_BITS-1:0] wait_sigs [SLOTS];
    logic                      all_mode  [SLOTS];
    logic                      blocked   [SLOTS];
    logic [4:0]                slot_count;

    t_event_result due_results [$];

    function automatic t_event_result predict_flags(
        input logic [2:0]                 op,
        input logic [FIELD_TASK_BITS-1:0] tsk,
        input logic [FIELD_SIG_BITS-1:0]  sig,
        input logic                       all,
        input logic                       may_block
    );
        t_event_result             r;
        logic [4:0]                lim;
        logic [FIELD_SIG_BITS-1:0] got;
        r.status  = ST_OK;
        r.sigs    = '0;
        r.woke    = 1'b0;
        r.task_id = tsk;
        lim = (slot_count < 5'd16) ? slot_count : 5'd16;
        if (op <= OP_TIMEOUT && {1'b0, tsk} >= lim) begin
            r.status = ST_BAD_TASK;
        end else if (op <= OP_TIMEOUT) begin
            case (op)
                OP_WAIT: begin
                    // a repeated wait starts over, even from the waiting state
                    blocked[tsk]   = 1'b0;
                    all_mode[tsk]  = all;
                    wait_sigs[tsk] = sig;
                    got = sig & pend_sigs[tsk];
                    if (all && got != sig)
                        got = '0;
                    if (got != '0) begin
                        pend_sigs[tsk] &= ~got;
                        r.sigs = got;
                    end else if (!may_block) begin
                        r.status = ST_WOULD_BLOCK;
                    end else begin
                        blocked[tsk] = 1'b1;
                        r.status = ST_NOW_WAITING;
                    end
                end
                OP_SEND, OP_PULSE: begin
                    pend_sigs[tsk] |= sig;
                    got = pend_sigs[tsk] & wait_sigs[tsk];
                    // a pulse only lasts for the wake check
                    if (op == OP_PULSE)
                        pend_sigs[tsk] &= ~sig;
                    if (blocked[tsk]) begin
                        if (all_mode[tsk] && got != wait_sigs[tsk])
                            got = '0;
                        if (got != '0) begin
                            pend_sigs[tsk] &= ~got;
                            blocked[tsk] = 1'b0;
                            r.sigs = got;
                            r.woke = 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    pend_sigs[tsk] &= ~sig;
                end
                default: begin
                    if (blocked[tsk]) begin
                        blocked[tsk] = 1'b0;
                        r.status = ST_TIMED_OUT;
                        r.woke = 1'b1;
                    end
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_event_result want;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                pend_sigs[i] = '0;
                wait_sigs[i] = '0;
                all_mode[i]  = 1'b0;
                blocked[i]   = 1'b0;
            end
            slot_count = TASK_COUNT_RST;
            due_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == TASK_COUNT_ADDR)
                slot_count = pwdata[4:0];
            if (i_valid && !o_stall)
                due_results.push_back(predict_flags(i_op, i_task_req, i_sig_mask,
                                                    i_wait_all, i_may_block));
            if (o_valid && !i_stall) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with nothing expected: status %0d task %0d",
                           o_status, o_task_out);
                    errs++;
                end else begin
                    want = due_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        errs++;
                    end
                    if (o_sigs_out !== want.sigs) begin
                        $error("sigs_out: expected %h, actual %h", want.sigs, o_sigs_out);
                        errs++;
                    end
                    if (o_woke !== want.woke) begin
                        $error("woke: expected %0d, actual %0d", want.woke, o_woke);
                        errs++;
                    end
                    if (o_task_out !== want.task_id) begin
                        $error("task_out: expected %0d, actual %0d", want.task_id,
                               o_task_out);
                        errs++;
                    end
                end
            end
        end
        o_fail_count  <= o_fail_count + errs;
        o_results_due <= due_results.size();
    end

endmodule

// ===== verif/task_event_flags_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_event_flags_unit_tb
// Drives wait, send, pulse, clear and timeout items into the event-flag unit
// under several task_count settings, with random gaps and output stalls;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module task_event_flags_unit_tb;
    import tefu_pkg::*;

    localparam int         WATCHDOG_LIMIT  = 1000;
    localparam int         SETTLE_CYCLES   = 4;
    localparam logic [1:0] TASK_COUNT_ADDR = REG_TASK_COUNT << 2;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [2:0]                 i_op;
    logic [FIELD_TASK_BITS-1:0] i_task_req;
    logic [FIELD_SIG_BITS-1:0]  i_sig_mask;
    logic                       i_wait_all;
    logic                       i_may_block;
    logic                       o_valid;
    logic                       i_stall;
    logic [2:0]                 o_status;
    logic [FIELD_SIG_BITS-1:0]  o_sigs_out;
    logic                       o_woke;
    logic [FIELD_TASK_BITS-1:0] o_task_out;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [1:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    int fail_count;
    int results_due;
    int slot_limit;
    int live_items;
    int idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    task_event_flags_unit dut (.*);

    task_event_flags_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_op, .i_task_req, .i_sig_mask,
        .i_wait_all, .i_may_block, .o_valid, .i_stall, .o_status, .o_sigs_out,
        .o_woke, .o_task_out, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_results_due(results_due)
    );

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [FIELD_SIG_BITS-1:0] sparse_mask();
        logic [FIELD_SIG_BITS-1:0] m;
        m = 16'h1 << $urandom_range(0, 15);
        if ($urandom_range(0, 1))
            m |= 16'h1 << $urandom_range(0, 15);
        return m;
    endfunction

    function automatic logic [FIELD_SIG_BITS-1:0] any_mask();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 65535));
            default: return sparse_mask();
        endcase
    endfunction

    function automatic logic [FIELD_TASK_BITS-1:0] pick_task();
        if (slot_limit > 0 && $urandom_range(0, 9) != 0)
            return 4'($urandom_range(0, slot_limit - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    // receiver: free runs, now and then a long one, broken by stalls
    initial begin
        i_stall <= 1'b0;
        forever begin
            repeat ($urandom_range(0, 9) == 0 ? 120 : $urandom_range(1, 20))
                @(posedge i_clk);
            i_stall <= 1'b1;
            repeat (1 + pick_gap()) @(posedge i_clk);
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(
        input logic [2:0]                 op,
        input logic [FIELD_TASK_BITS-1:0] tsk,
        input logic [FIELD_SIG_BITS-1:0]  mask,
        input logic                       all,
        input logic                       blk
    );
        int gap;
        i_valid     <= 1'b1;
        i_op        <= op;
        i_task_req  <= tsk;
        i_sig_mask  <= mask;
        i_wait_all  <= all;
        i_may_block <= blk;
        do @(posedge i_clk); while (o_stall);
        if (op <= OP_TIMEOUT && tsk < slot_limit)
            live_items++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        // let the last input transfer reach the checker before results_due is read
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_task_count(input logic [4:0] value);
        drain_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= TASK_COUNT_ADDR;
        pwdata  <= {27'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        slot_limit = (value < 5'd16) ? value : 16;
    endtask

    // a wait followed by sends or pulses to the same task and at times a timeout or clear, else a stray item
    task automatic run_sequence();
        logic [FIELD_TASK_BITS-1:0] t;
        logic [FIELD_SIG_BITS-1:0]  m;
        logic                       all;
        if ($urandom_range(0, 3) == 0) begin
            send_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), any_mask(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
            t   = pick_task();
            m   = ($urandom_range(0, 5) == 0) ? any_mask() : sparse_mask();
            all = 1'($urandom_range(0, 1));
            send_item(OP_WAIT, t, m, all, $urandom_range(0, 4) != 0);
            repeat ($urandom_range(1, 3))
                send_item(($urandom_range(0, 2) == 0) ? OP_PULSE : OP_SEND, t,
                          (m & 16'($urandom_range(0, 65535)))
                              | (($urandom_range(0, 4) == 0) ? sparse_mask() : 16'h0),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            case ($urandom_range(0, 3))
                0:       send_item(OP_TIMEOUT, t, any_mask(), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
                1:       send_item(OP_CLEAR, t, any_mask(), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
                default: ;
            endcase
        end
    endtask

    task automatic run_random(input int n);
        live_items = 0;
        while (live_items < n) run_sequence();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_op        <= OP_WAIT;
        i_task_req  <= '0;
        i_sig_mask  <= '0;
        i_wait_all  <= 1'b0;
        i_may_block <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        slot_limit  = 16;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_task_count(5'd16);
        // empty mask: never met, so would-block or wait for a timeout
        send_item(OP_WAIT,    4'd0,  16'h0000, 1'b0, 1'b0);
        send_item(OP_WAIT,    4'd0,  16'h0000, 1'b1, 1'b1);
        send_item(OP_TIMEOUT, 4'd0,  16'hFFFF, 1'b0, 1'b0);
        send_item(OP_TIMEOUT, 4'd0,  16'h0000, 1'b1, 1'b1);
        send_item(OP_SEND,    4'd1,  16'hFFFF, 1'b0, 1'b0);
        send_item(OP_WAIT,    4'd1,  16'h00F0, 1'b0, 1'b1);
        send_item(OP_WAIT,    4'd1,  16'hFFFF, 1'b1, 1'b0);
        send_item(OP_WAIT,    4'd2,  16'h8001, 1'b1, 1'b1);
        send_item(OP_SEND,    4'd2,  16'h0001, 1'b0, 1'b0);
        // waiting task waits again
        send_item(OP_WAIT,    4'd2,  16'h8001, 1'b1, 1'b1);
        send_item(OP_PULSE,   4'd2,  16'h8000, 1'b1, 1'b1);
        send_item(OP_PULSE,   4'd3,  16'h0F0F, 1'b0, 1'b0);
        send_item(OP_WAIT,    4'd3,  16'h0F0F, 1'b0, 1'b0);
        send_item(OP_SEND,    4'd15, 16'h5555, 1'b0, 1'b0);
        send_item(OP_CLEAR,   4'd15, 16'h0005, 1'b0, 1'b0);
        send_item(OP_WAIT,    4'd15, 16'hFFFF, 1'b0, 1'b0);
        send_item(3'd5,       4'd4,  16'hA5A5, 1'b1, 1'b1);
        send_item(3'd6,       4'd4,  16'h5A5A, 1'b0, 1'b1);
        send_item(3'd7,       4'd4,  16'hFFFF, 1'b1, 1'b0);
        send_item(OP_WAIT,    4'd4,  16'h0002, 1'b0, 1'b1);
        send_item(OP_SEND,    4'd4,  16'h0006, 1'b0, 1'b0);
        send_item(OP_WAIT,    4'd15, 16'hFFFF, 1'b1, 1'b1);
        send_item(OP_SEND,    4'd15, 16'hFFFF, 1'b0, 1'b0);
        run_random(180);

        // no slots in use: every wait, send, pulse, clear or timeout is rejected
        set_task_count(5'd0);
        repeat (10) run_sequence();
        set_task_count(5'd1);
        run_random(120);
        // above the slot count, acts as all slots
        set_task_count(5'd31);
        run_random(200);
        set_task_count(5'($urandom_range(2, 15)));
        run_random(150);
        set_task_count(5'd16);
        run_random(80);

        drain_results();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
